// File: hdl/rsas_pkg.sv
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared types and constants for the rotated sorted array search block.
// ----------------------------------------------------------------------------
package rsas_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned POS_W            = 10;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
  } rsas_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsas_rsp_t;

  // shared compare unit result
  typedef struct packed {
    logic lt;  // a < b, signed
    logic eq;  // a == b
  } rsas_cmp_t;

endpackage

// File: hdl/rsas_cmp.sv
// ----------------------------------------------------------------------------
// rsas_cmp
// Shared signed magnitude / equality compare unit.
// ----------------------------------------------------------------------------
module rsas_cmp
  import rsas_pkg::*;
(
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output rsas_cmp_t                res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// File: hdl/rsas_store.sv
// ----------------------------------------------------------------------------
// rsas_store
// Element memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsas_store
  import rsas_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_ELEMENTS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rotated_sorted_array_search.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Store of distinct values, sorted then rotated, with binary key search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries one request:
//   clear, append or search. Output channel (out_valid_o / out_stall_i /
//   out_rsp_o) carries one response per search request only.
//   Clear and append do not leave the idle state, so in_stall_o stays low.
//   Appends past MAX_ELEMENTS are dropped. The rotation point is tracked
//   while appending, so a search needs no pivot pass.
//   Search: an empty store goes straight to the respond state. Otherwise
//   min read, max read and range check (ST_MIN, ST_MAX, ST_CHK) come
//   first, then each probe is one memory read and one compare on the
//   shared comparator (ST_PROBE, ST_CMP), then ST_RESP closes out.
//   The single memory read port sets the per-probe cost.
//   in_stall_o is high for the whole search; one request at a time.
//   A finished response sits in the output register while out_stall_i is
//   high; a new request is taken meanwhile, and a later search waits in
//   its respond state until the register frees up.
//   Reset clears count, rotation point and last value; memory contents
//   are not cleared (entries beyond count are never read).
// ----------------------------------------------------------------------------
module rotated_sorted_array_search
  import rsas_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rsas_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rsas_rsp_t out_rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MIN   = 3'd1;  // read minimum at rotation point
  localparam logic [2:0] ST_MAX   = 3'd2;  // read maximum, check key >= min
  localparam logic [2:0] ST_CHK   = 3'd3;  // check key <= max
  localparam logic [2:0] ST_PROBE = 3'd4;  // issue probe read
  localparam logic [2:0] ST_CMP   = 3'd5;  // compare probe data
  localparam logic [2:0] ST_RESP  = 3'd6;  // hand result to output reg

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   rot_q, rot_d;
  logic [DATA_W-1:0]  last_q, last_d;
  logic [DATA_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   hi_q, hi_d;
  logic [CNT_W-1:0]   m_q, m_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               oor_q, oor_d;
  logic               found_q, found_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  rsas_rsp_t          out_rsp_q, out_rsp_d;

  logic               in_acc;
  logic               full;
  logic               out_free;
  logic [DATA_W-1:0]  rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]  cmp_a, cmp_b;
  rsas_cmp_t          cmp;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W:0]     idx_sum;
  logic [CNT_W:0]     idx_wrap;
  logic [IDX_W-1:0]   probe_idx;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   max_idx;
  logic [IDX_W+POS_W-1:0] pos_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign full        = (count_q == CNT_W'(MAX_ELEMENTS));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Shared comparator: append compares incoming value with last value;
  // search compares the key with whatever the memory just returned.
  assign cmp_a = (state_q == ST_IDLE) ? in_req_i.value : key_q;
  assign cmp_b = (state_q == ST_IDLE) ? last_q : rd_data;

  rsas_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  // Midpoint of [lo, hi) and its wrap onto stored index space.
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CNT_W:1];
  assign idx_sum   = {1'b0, mid} + {{(CNT_W + 1 - IDX_W){1'b0}}, rot_q};
  assign idx_wrap  = (idx_sum >= {1'b0, count_q}) ? (idx_sum - {1'b0, count_q}) : idx_sum;
  assign probe_idx = idx_wrap[IDX_W-1:0];

  // Maximum sits just before the rotation point, or at the end.
  assign cnt_m1  = count_q - CNT_W'(1);
  assign max_idx = (rot_q == '0) ? cnt_m1[IDX_W-1:0] : (rot_q - IDX_W'(1));

  assign pos_ext = {{POS_W{1'b0}}, idx_q};

  assign mem_we = in_acc && (in_req_i.command == CMD_APPEND) && !full;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rot_q;
    unique case (state_q)
      ST_MIN: begin
        mem_re    = 1'b1;
        mem_raddr = rot_q;
      end
      ST_MAX: begin
        mem_re    = 1'b1;
        mem_raddr = max_idx;
      end
      ST_PROBE: begin
        mem_re    = (lo_q < hi_q);
        mem_raddr = probe_idx;
      end
      default: begin
        mem_re    = 1'b0;
      end
    endcase
  end

  rsas_store #(
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_req_i.value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rot_d       = rot_q;
    last_d      = last_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    m_d         = m_q;
    idx_d       = idx_q;
    oor_d       = oor_q;
    found_d     = found_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.command)
            CMD_CLEAR: begin
              count_d = '0;
              rot_d   = '0;
            end
            CMD_APPEND: begin
              if (!full) begin
                if (count_q == '0) begin
                  rot_d = '0;
                end else if (cmp.lt) begin
                  rot_d = count_q[IDX_W-1:0];
                end
                count_d = count_q + CNT_W'(1);
                last_d  = in_req_i.value;
              end
            end
            CMD_SEARCH: begin
              key_d = in_req_i.value;
              if (count_q == '0) begin
                found_d = 1'b0;
                pos_d   = '0;
                state_d = ST_RESP;
              end else begin
                state_d = ST_MIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MIN: begin
        state_d = ST_MAX;
      end
      ST_MAX: begin
        // rd_data holds the minimum
        oor_d   = cmp.lt;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // rd_data holds the maximum; max < key means neither lt nor eq
        if (oor_q || (!cmp.lt && !cmp.eq)) begin
          found_d = 1'b0;
          pos_d   = '0;
          state_d = ST_RESP;
        end else begin
          lo_d    = '0;
          hi_d    = count_q;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          m_d     = mid;
          idx_d   = probe_idx;
          state_d = ST_CMP;
        end else begin
          found_d = 1'b0;
          pos_d   = '0;
          state_d = ST_RESP;
        end
      end
      ST_CMP: begin
        if (cmp.eq) begin
          found_d = 1'b1;
          pos_d   = pos_ext[POS_W-1:0];
          state_d = ST_RESP;
        end else begin
          if (cmp.lt) begin
            hi_d = m_q;
          end else begin
            lo_d = m_q + CNT_W'(1);
          end
          state_d = ST_PROBE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_rsp_d.found    = found_q;
          out_rsp_d.position = pos_q;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rot_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rot_q       <= rot_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    m_q       <= m_d;
    idx_q     <= idx_d;
    oor_q     <= oor_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    out_rsp_q <= out_rsp_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_rot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> ({1'b0, rot_q} < {1'b0, count_q}))
    else $error("rotation point outside stored range");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) && (lo_q < hi_q) |-> ({1'b0, probe_idx} < {1'b0, count_q}))
    else $error("probe index outside stored range");

  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("response raised outside respond state");
`endif

endmodule

// File: bench/rotated_sorted_array_search_tb.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_tb
// Self-checking bench: streams clear, append and search requests into the
// block under random back-pressure and idling on both channels, predicts each
// search answer from a shadow copy of the store and checks it field by field.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsas_pkg::*;

  localparam int unsigned        DEPTH        = MAX_ELEMENTS_DEF;
  localparam logic [1:0]         CMD_UNUSED   = 2'd3;  // undefined opcode, must be dropped
  localparam int                 RANDOM_ITEMS = 120;   // on top of the full-capacity set
  localparam int unsigned        CYCLE_LIMIT  = 1000000;
  localparam int                 DRAIN_CYCLES = 64;    // extra wait after the last answer
  localparam int                 TAIL_ITEMS   = 150;   // last requests go without idling
  localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX      = 32'sh7fff_ffff;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  rsas_req_t req_data  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsas_rsp_t rsp_data;

  rotated_sorted_array_search u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_req_i    (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_rsp_o   (rsp_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  rsas_req_t   request_q[$];         // requests waiting for the driver
  rsas_rsp_t   search_answers_q[$];  // predicted answers, oldest first

  // Shadow of the block's contents, updated on every accepted request.
  logic signed [31:0] shadow_mem [DEPTH];
  int unsigned        shadow_count = 0;
  logic [POS_W-1:0]   shadow_pivot = '0;   // index of the minimum
  logic signed [31:0] shadow_last  = '0;   // most recently appended value

  int          gen_vals[$];          // values of the set the generator last built
  int          stim_items      = 0;
  int          mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  bit          req_taken       = 1'b0;
  bit          stim_done       = 1'b0;
  int          in_gap_left     = 0;
  int          rsp_hold_left   = 0;

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // Once everything is queued and the backlog is short, both sides run flat out.
  function automatic bit calm_tail();
    return stim_done && (request_q.size() < TAIL_ITEMS);
  endfunction

  // One line per mismatch, and count it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request to the shadow store and, for a
  // search, returns the answer the block must give.
  // --------------------------------------------------------------------------
  function automatic void apply_request(input rsas_req_t rq, output bit has_answer,
                                        output rsas_rsp_t answer);
    logic signed [31:0] key;
    logic signed [31:0] min_val;
    logic signed [31:0] max_val;
    logic signed [31:0] probe;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        mid;
    int unsigned        idx;
    has_answer = 1'b0;
    answer     = '0;
    key        = rq.value;
    case (rq.command)
      CMD_CLEAR: begin
        shadow_count = 0;
        shadow_pivot = '0;
      end
      CMD_APPEND: begin
        // a full store silently drops the value
        if (shadow_count < DEPTH) begin
          if (shadow_count == 0) begin
            shadow_pivot = '0;
          end else if (key < shadow_last) begin
            // a drop marks the new minimum; equal values leave the pivot
            shadow_pivot = shadow_count[POS_W-1:0];
          end
          shadow_mem[shadow_count] = key;
          shadow_count++;
          shadow_last = key;
        end
      end
      CMD_SEARCH: begin
        has_answer = 1'b1;
        if (shadow_count != 0) begin
          min_val = shadow_mem[shadow_pivot];
          max_val = shadow_mem[(shadow_pivot == 0) ? shadow_count - 1 : shadow_pivot - 1];
          // keys outside min..max are rejected before any probe
          if (!(key < min_val || key > max_val)) begin
            lo = 0;
            hi = shadow_count;
            // binary search over logical indices; logical i sits at
            // stored (i + pivot) mod count. Unsorted data still terminates.
            while (lo < hi && !answer.found) begin
              mid = lo + (hi - lo) / 2;
              idx = mid + shadow_pivot;
              if (idx >= shadow_count) idx -= shadow_count;
              probe = shadow_mem[idx];
              if (probe == key) begin
                answer.found    = 1'b1;
                answer.position = idx[POS_W-1:0];
              end else if (key < probe) begin
                hi = mid;
              end else begin
                lo = mid + 1;
              end
            end
          end
        end
      end
      default: ;  // unknown opcode: no effect, no answer
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and predictor hook, both at the rising edge. The output is checked
  // before the accepted request is predicted, so an answer pushed on this edge
  // can never be matched against a response leaving on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : edge_check
    bit        new_answer;
    rsas_rsp_t predicted;
    rsas_rsp_t head;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (rsp_valid && !rsp_stall) begin
        if (search_answers_q.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending: found=%0b position=%0d",
                                    rsp_data.found, rsp_data.position));
        end else begin
          head = search_answers_q.pop_front();
          if (rsp_data.found !== head.found)
            report_mismatch($sformatf("found: got %0b, want %0b",
                                      rsp_data.found, head.found));
          if (rsp_data.position !== head.position)
            report_mismatch($sformatf("position: got %0d, want %0d",
                                      rsp_data.position, head.position));
        end
      end
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        apply_request(req_data, new_answer, predicted);
        if (new_answer) search_answers_q.push_back(predicted);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver, falling edge. A request is held untouched until the edge
  // that took it; only then may the driver idle or load the next one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (in_gap_left != 0) begin
        req_valid   <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (!calm_tail() && $urandom_range(0, 9) == 0) begin
        // start an idle burst; in_gap_left counts down its remainder
        req_valid   <= 1'b0;
        in_gap_left <= $urandom_range(0, 17);
      end else if (request_q.size() != 0) begin
        req_data  <= request_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response back-pressure: random stall bursts, counted down in rsp_hold_left.
  always @(negedge clk) begin : rsp_pressure
    if (calm_tail()) begin
      rsp_stall     <= 1'b0;
      rsp_hold_left <= 0;
    end else if (rsp_hold_left != 0) begin
      rsp_stall     <= 1'b1;
      rsp_hold_left <= rsp_hold_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      rsp_stall     <= 1'b1;
      rsp_hold_left <= $urandom_range(0, 17);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_request(input logic [1:0] cmd, input int val);
    rsas_req_t rq;
    rq.command = cmd;
    rq.value   = val;
    request_q.push_back(rq);
    if (cmd != CMD_UNUSED) stim_items++;
  endtask

  // Clear, then append n distinct ascending values rotated by a random amount.
  // Values are either spread over the whole 32-bit range or tightly packed so
  // that absent in-range keys sit right next to stored ones. Sometimes the set
  // is pinned to the most negative or most positive value.
  task automatic load_rotated_set(input int unsigned n);
    longint      offs[$];
    longint      span;
    longint      room;
    longint      base;
    int unsigned shift;
    int unsigned anchor;
    span = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 3))
                                       : 64'sd4294967295 / (n + 1);
    offs.push_back(0);
    for (int unsigned i = 1; i < n; i++)
      offs.push_back(offs[i-1] + 1 + longint'($urandom) % span);
    room   = 64'sd4294967295 - offs[n-1];
    anchor = $urandom_range(0, 5);
    if (anchor == 0)
      base = -64'sd2147483648;
    else if (anchor == 1)
      base = 64'sd2147483647 - offs[n-1];
    else
      base = -64'sd2147483648 + longint'({$urandom, $urandom} % (room + 1));
    gen_vals.delete();
    foreach (offs[i]) gen_vals.push_back(int'(base + offs[i]));
    push_request(CMD_CLEAR, $urandom);
    shift = $urandom_range(0, n - 1);
    for (int unsigned i = 0; i < n; i++)
      push_request(CMD_APPEND, gen_vals[(i + shift) % n]);
  endtask

  // Mostly keys that are stored; also neighbors, both sides just past the
  // range, random keys and the two extremes.
  function automatic int pick_key();
    int          k;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (gen_vals.size() == 0 && sel < 8) sel = 8;
    case (sel)
      0, 1, 2, 3, 4: k = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
      5: k = gen_vals[$urandom_range(0, gen_vals.size() - 1)]
             + (($urandom_range(0, 1) != 0) ? 1 : -1);
      6: k = gen_vals[0] - 1;
      7: k = gen_vals[gen_vals.size() - 1] + 1;
      8: k = $urandom;
      default: k = ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
    endcase
    return k;
  endfunction

  task automatic random_requests(input int target);
    int          stop_at;
    int          v;
    int unsigned kind;
    int unsigned n;
    stop_at = stim_items + target;
    while (stim_items < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // well-formed set, mostly small
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 20);
        load_rotated_set(n);
        repeat ($urandom_range(1, 8)) push_request(CMD_SEARCH, pick_key());
      end else if (kind == 7) begin
        // break the ordering: random values and repeats of the last one
        repeat ($urandom_range(1, 5)) begin
          v = (gen_vals.size() != 0 && $urandom_range(0, 2) == 0)
              ? gen_vals[gen_vals.size() - 1] : int'($urandom);
          push_request(CMD_APPEND, v);
          gen_vals.push_back(v);
        end
        repeat ($urandom_range(1, 4)) push_request(CMD_SEARCH, pick_key());
      end else if (kind == 8) begin
        // empty store, sometimes with a stray opcode in between
        push_request(CMD_CLEAR, $urandom);
        gen_vals.delete();
        if ($urandom_range(0, 1) != 0) push_request(CMD_UNUSED, $urandom);
        push_request(CMD_SEARCH, pick_key());
      end else begin
        repeat ($urandom_range(1, 4)) push_request(CMD_SEARCH, pick_key());
      end
    end
  endtask

  // Hold the sender until every queued request went in and every answer came.
  task automatic wait_for_answers();
    while (request_q.size() != 0 || req_valid || search_answers_q.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: search on an empty store, stray opcode, a six-entry set that
    // holds both extremes and wraps between them, then one- and two-entry cases.
    push_request(CMD_SEARCH, 0);
    push_request(CMD_UNUSED, -1);
    push_request(CMD_CLEAR, 0);
    push_request(CMD_APPEND, 5);
    push_request(CMD_APPEND, 9);
    push_request(CMD_APPEND, VAL_MAX);
    push_request(CMD_APPEND, VAL_MIN);   // drop: pivot moves to index 3
    push_request(CMD_APPEND, -7);
    push_request(CMD_APPEND, 0);
    push_request(CMD_SEARCH, VAL_MIN);
    push_request(CMD_SEARCH, VAL_MAX);
    push_request(CMD_SEARCH, 0);
    push_request(CMD_SEARCH, 5);
    push_request(CMD_SEARCH, 6);         // in range, not stored
    push_request(CMD_UNUSED, 5);
    push_request(CMD_CLEAR, -1);
    push_request(CMD_APPEND, 42);        // first append resets the pivot
    push_request(CMD_SEARCH, 42);
    push_request(CMD_SEARCH, 41);        // below min
    push_request(CMD_SEARCH, 43);        // above max
    push_request(CMD_APPEND, 42);        // equal value, pivot stays
    push_request(CMD_SEARCH, 42);
    push_request(CMD_CLEAR, 0);
    push_request(CMD_SEARCH, 42);

    random_requests(RANDOM_ITEMS / 2);

    // One set at full capacity, a few appends that must be dropped, then
    // enough searches to land on high stored indices.
    load_rotated_set(DEPTH);
    repeat (6) push_request(CMD_APPEND, $urandom);
    repeat (40) push_request(CMD_SEARCH, pick_key());

    // sender pause: let the block and the output side drain completely
    wait_for_answers();

    random_requests(RANDOM_ITEMS / 2);
    stim_done = 1'b1;

    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (search_answers_q.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", search_answers_q.size()));
    if (mismatch_count == 0) begin
      $display("rotated_sorted_array_search_tb OK");
    end else begin
      $display("rotated_sorted_array_search_tb NOT OK");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("rotated_sorted_array_search_tb NOT OK");
    $finish;
  end

endmodule
